FILE: sv/bre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bre_pkg: shared types and constants for the battery runtime estimator
// Holds the item and result formats, the register map, the controller to
// datapath command and status groups and the fixed divider sizes.
// ----------------------------------------------------------------------------
package bre_pkg;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // register map, word index on paddr[3:2]
    localparam logic [1:0] REG_MIN_DROP     = 2'd0;
    localparam logic [1:0] REG_REANCHOR     = 2'd1;
    localparam logic [1:0] REG_HOUR_LIMIT   = 2'd2;

    // register reset values
    localparam logic [6:0]  MIN_DROP_RST    = 7'd2;
    localparam logic [6:0]  REANCHOR_RST    = 7'd20;
    localparam logic [15:0] HOUR_LIMIT_RST  = 16'd9999;

    localparam logic [11:0] SEC_PER_HOUR    = 12'd3600;

    // numerator: 7-bit percent times 32-bit elapsed seconds
    localparam int NUM_W     = 39;
    // denominator: 7-bit drop times 3600
    localparam int DEN_W     = 19;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

    typedef struct packed {
        logic              req_type;
        logic [6:0]        charge_pct;
        logic              charging_flag;
        logic signed [31:0] now_seconds;
    } t_item;

    typedef struct packed {
        logic        estimate_valid;
        logic [15:0] hours_left;
    } t_result;

    typedef struct packed {
        logic [6:0]  min_drop;
        logic [6:0]  reanchor_drop;
        logic [15:0] hour_limit;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic sample_wr;
        logic query_ld;
        logic mul_ld;
        logic div_step;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic est_ok;
        logic div_last;
    } t_sts;

endpackage

FILE: sv/battery_runtime_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_runtime_estimator: remaining battery hours from percent samples
// Tracks an anchor point and the latest sample and answers runtime queries.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A sample item is
// absorbed at that edge, busy stays low and no result follows, so samples
// can arrive every cycle. A query raises busy and produces exactly one
// result, shown for a single cycle with o_result_strobe; the receiver must
// take it then, there is no back-pressure. A query with no estimate goes
// from the multiply state straight to output; one with an estimate passes
// through multiply, restoring-divider steps that each retire one quotient
// bit of the 39-bit product, and output; no item is taken before it ends.
// Registers at APB byte addresses 0, 4 and 8 are to be written by the user
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module battery_runtime_estimator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // item command channel
    input  logic             start,
    output logic             busy,
    input  bre_pkg::t_item   i_item,
    // result channel
    output logic             o_result_strobe,
    output bre_pkg::t_result o_result,
    // configuration port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    bre_pkg::t_cfg r_cfg;
    bre_pkg::t_cmd w_cmd;
    bre_pkg::t_sts w_sts;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // register write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_drop      <= bre_pkg::MIN_DROP_RST;
            r_cfg.reanchor_drop <= bre_pkg::REANCHOR_RST;
            r_cfg.hour_limit    <= bre_pkg::HOUR_LIMIT_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                bre_pkg::REG_MIN_DROP:   r_cfg.min_drop      <= pwdata[6:0];
                bre_pkg::REG_REANCHOR:   r_cfg.reanchor_drop <= pwdata[6:0];
                bre_pkg::REG_HOUR_LIMIT: r_cfg.hour_limit    <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // register read mux
    always_comb begin
        case (paddr[3:2])
            bre_pkg::REG_MIN_DROP:   prdata = {25'd0, r_cfg.min_drop};
            bre_pkg::REG_REANCHOR:   prdata = {25'd0, r_cfg.reanchor_drop};
            bre_pkg::REG_HOUR_LIMIT: prdata = {16'd0, r_cfg.hour_limit};
            default:                 prdata = 32'd0;
        endcase
    end

    bre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_item.req_type),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (busy),
        .o_strobe   (o_result_strobe)
    );

    bre_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .o_sts    (w_sts),
        .o_result (o_result)
    );

endmodule

FILE: sv/bre_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bre_ctrl: sequencing controller
// Accepts items, steps a query through multiply, divide and output, and
// drives the busy flag and the result strobe.
// ----------------------------------------------------------------------------
module bre_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_req_type,
    input  bre_pkg::t_sts i_sts,
    output bre_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_strobe
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == bre_pkg::REQ_QUERY) begin
                        o_cmd.query_ld = 1'b1;
                        n_state        = S_MUL;
                    end else begin
                        o_cmd.sample_wr = 1'b1;
                    end
                end
            end
            S_MUL: begin
                if (i_sts.est_ok) begin
                    o_cmd.mul_ld = 1'b1;
                    n_state      = S_DIV;
                end else begin
                    n_state      = S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_OUT);

endmodule

FILE: sv/bre_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bre_dp: estimator datapath
// Holds the anchor and the latest sample, evaluates the estimate checks,
// forms percent times elapsed and divides it by drop times 3600 with a
// restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bre_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bre_pkg::t_cmd    i_cmd,
    input  bre_pkg::t_item   i_item,
    input  bre_pkg::t_cfg    i_cfg,
    output bre_pkg::t_sts    o_sts,
    output bre_pkg::t_result o_result
);

    // battery state
    logic                r_anchor_valid;
    logic [6:0]          r_base_pct;
    logic signed [31:0]  r_anchor_stamp;
    logic [6:0]          r_cur_pct;
    logic                r_on_charger;

    // query working registers
    logic                         r_ok;
    logic [31:0]                  r_elapsed;
    logic [bre_pkg::DEN_W-1:0]    r_den;
    logic [bre_pkg::NUM_W-1:0]    r_quo;
    logic [bre_pkg::DEN_W-1:0]    r_rem;
    logic [bre_pkg::DIV_CNT_W-1:0] r_cnt;

    logic                w_move;
    logic [6:0]          w_samp_drop;
    logic [6:0]          w_drop;
    logic signed [32:0]  w_elapsed;
    logic                w_ok;
    logic [bre_pkg::DEN_W:0]   w_shift;
    logic [bre_pkg::DEN_W+1:0] w_trial;

    // re-anchor decision for a sample
    assign w_samp_drop = r_base_pct - i_item.charge_pct;
    always_comb begin
        w_move = !r_anchor_valid || i_item.charging_flag ||
                 (i_item.charge_pct > r_base_pct) ||
                 ($signed(i_item.now_seconds) < r_anchor_stamp) ||
                 (w_samp_drop >= i_cfg.reanchor_drop);
    end

    // estimate checks for a query
    assign w_drop    = r_base_pct - r_cur_pct;
    assign w_elapsed = 33'($signed(i_item.now_seconds)) - 33'(r_anchor_stamp);
    assign w_ok      = r_anchor_valid && !r_on_charger &&
                       (r_cur_pct <= r_base_pct) && (w_drop != 7'd0) &&
                       (w_drop >= i_cfg.min_drop) &&
                       !w_elapsed[32] && (w_elapsed != 33'sd0);

    // battery state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor_valid <= 1'b0;
            r_base_pct     <= 7'd0;
            r_anchor_stamp <= 32'sd0;
            r_cur_pct      <= 7'd0;
            r_on_charger   <= 1'b0;
        end else if (i_cmd.sample_wr) begin
            r_cur_pct    <= i_item.charge_pct;
            r_on_charger <= i_item.charging_flag;
            if (w_move) begin
                r_anchor_valid <= 1'b1;
                r_base_pct     <= i_item.charge_pct;
                r_anchor_stamp <= i_item.now_seconds;
            end
        end
    end

    // divider trial subtract
    assign w_shift = {r_rem, r_quo[bre_pkg::NUM_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_den};

    // query capture, multiply and divide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.query_ld) begin
                r_ok      <= w_ok;
                r_elapsed <= w_elapsed[31:0];
                r_den     <= bre_pkg::DEN_W'(w_drop) *
                             bre_pkg::DEN_W'(bre_pkg::SEC_PER_HOUR);
            end
            if (i_cmd.mul_ld) begin
                r_quo <= bre_pkg::NUM_W'(r_cur_pct) * bre_pkg::NUM_W'(r_elapsed);
                r_rem <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
                if (!w_trial[bre_pkg::DEN_W+1]) begin
                    r_rem <= w_trial[bre_pkg::DEN_W-1:0];
                    r_quo <= {r_quo[bre_pkg::NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[bre_pkg::DEN_W-1:0];
                    r_quo <= {r_quo[bre_pkg::NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_sts.est_ok   = r_ok;
    assign o_sts.div_last = (r_cnt == bre_pkg::DIV_LAST);

    // saturated result
    always_comb begin
        o_result.estimate_valid = r_ok;
        if (!r_ok) begin
            o_result.hours_left = 16'd0;
        end else if (r_quo > bre_pkg::NUM_W'(i_cfg.hour_limit)) begin
            o_result.hours_left = i_cfg.hour_limit;
        end else begin
            o_result.hours_left = r_quo[15:0];
        end
    end

endmodule

FILE: sv/bre_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bre_chk: port-level checks for the battery runtime estimator
// Watches item transfers and result strobes over time.
// ----------------------------------------------------------------------------
module bre_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input bre_pkg::t_item   i_item,
    input logic             o_result_strobe,
    input bre_pkg::t_result o_result
);

    // a query transfer holds the block busy
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.req_type == bre_pkg::REQ_QUERY)) |=> busy)
        else $error("query transfer did not raise busy");

    // a sample transfer leaves the block free and gives no result
    a_sample_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.req_type == bre_pkg::REQ_SAMPLE))
        |=> (!busy && !o_result_strobe))
        else $error("sample transfer disturbed busy or strobe");

    // a result only comes out of a busy period
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (busy && $past(busy)))
        else $error("result strobe without a running query");

    // the result ends the query
    a_strobe_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> (!busy && !o_result_strobe))
        else $error("busy or strobe held after result");

    // no estimate reports zero hours
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_result.estimate_valid) |-> (o_result.hours_left == 16'd0))
        else $error("invalid estimate with nonzero hours");

endmodule

bind battery_runtime_estimator bre_chk u_bre_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_item          (i_item),
    .o_result_strobe (o_result_strobe),
    .o_result        (o_result)
);

FILE: tb/bre_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bre_checker: runtime estimate predictor and result scoreboard
// Watches the item, result and register channels of the battery runtime
// estimator. It keeps its own copy of the anchor, the latest sample and the
// register settings, works out the answer for every accepted query and
// compares each strobed result with the oldest answer still waiting.
// ----------------------------------------------------------------------------
module bre_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // item channel
    input  logic             i_start,
    input  logic             i_busy,
    input  bre_pkg::t_item   i_item,
    // result channel
    input  logic             i_result_strobe,
    input  bre_pkg::t_result i_result,
    // register port
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic [3:0]       i_paddr,
    input  logic [31:0]      i_pwdata,
    input  logic [31:0]      i_prdata,
    input  logic             i_pready,
    // totals for the top level
    output int               o_fail_count,
    output int               o_pending,
    output int               o_sample_count,
    output int               o_query_count,
    output int               o_estimate_count
);

    // register copies
    logic [6:0]         cfg_min_drop;
    logic [6:0]         cfg_reanchor;
    logic [15:0]        cfg_hour_limit;

    // battery state copies
    logic               anchor_set;
    logic [6:0]         base_pct;
    logic signed [31:0] base_stamp;
    logic [6:0]         level_pct;
    logic               on_charger;

    bre_pkg::t_result   answers_due[$];
    int                 fail_total;
    int                 samples_seen;
    int                 queries_seen;
    int                 estimates_seen;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch, %s: got %0d, expected %0d", $time, what, got, want);
        fail_total++;
    endtask

    // remaining hours for a query at now_s, from the current state
    function automatic bre_pkg::t_result runtime_for(input logic signed [31:0] now_s);
        bre_pkg::t_result   answer;
        logic [6:0]         drop;
        logic signed [32:0] span;
        longint unsigned    hours;
        answer = '0;
        if (!anchor_set || on_charger || level_pct > base_pct) return answer;
        drop = base_pct - level_pct;
        if (drop == 7'd0 || drop < cfg_min_drop) return answer;
        // exact 33-bit difference of the two stamps
        span = {now_s[31], now_s} - {base_stamp[31], base_stamp};
        if (span <= 0) return answer;
        hours = (64'(level_pct) * 64'(span[31:0])) /
                (64'(drop) * 64'(bre_pkg::SEC_PER_HOUR));
        if (hours > 64'(cfg_hour_limit)) hours = 64'(cfg_hour_limit);
        answer.estimate_valid = 1'b1;
        answer.hours_left     = hours[15:0];
        return answer;
    endfunction

    initial begin
        fail_total     = 0;
        samples_seen   = 0;
        queries_seen   = 0;
        estimates_seen = 0;
    end

    always @(posedge i_clk) begin : watch
        bre_pkg::t_result want;
        logic             move;
        logic [31:0]      read_want;
        logic             read_known;
        if (!i_rst_n) begin
            cfg_min_drop   = bre_pkg::MIN_DROP_RST;
            cfg_reanchor   = bre_pkg::REANCHOR_RST;
            cfg_hour_limit = bre_pkg::HOUR_LIMIT_RST;
            anchor_set     = 1'b0;
            base_pct       = '0;
            base_stamp     = '0;
            level_pct      = '0;
            on_charger     = 1'b0;
            answers_due.delete();
        end else begin
            // register transfers
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[3:2])
                        bre_pkg::REG_MIN_DROP:   cfg_min_drop   = i_pwdata[6:0];
                        bre_pkg::REG_REANCHOR:   cfg_reanchor   = i_pwdata[6:0];
                        bre_pkg::REG_HOUR_LIMIT: cfg_hour_limit = i_pwdata[15:0];
                        default: ;
                    endcase
                end else begin
                    read_known = 1'b1;
                    case (i_paddr[3:2])
                        bre_pkg::REG_MIN_DROP:   read_want = {25'd0, cfg_min_drop};
                        bre_pkg::REG_REANCHOR:   read_want = {25'd0, cfg_reanchor};
                        bre_pkg::REG_HOUR_LIMIT: read_want = {16'd0, cfg_hour_limit};
                        default: begin
                            read_known = 1'b0;
                            read_want  = '0;
                        end
                    endcase
                    if (read_known && i_prdata !== read_want)
                        report_mismatch($sformatf("register read at 0x%0h", i_paddr),
                                        i_prdata, read_want);
                end
            end

            // result transfers, compared with the oldest answer
            if (i_result_strobe) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("result with no query waiting", 1, 0);
                end else begin
                    want = answers_due.pop_front();
                    if (i_result.estimate_valid !== want.estimate_valid)
                        report_mismatch("estimate_valid", i_result.estimate_valid,
                                        want.estimate_valid);
                    if (i_result.hours_left !== want.hours_left)
                        report_mismatch("hours_left", i_result.hours_left, want.hours_left);
                end
            end

            // item transfers
            if (i_start && !i_busy) begin
                if (i_item.req_type == bre_pkg::REQ_SAMPLE) begin
                    move = !anchor_set || i_item.charging_flag ||
                           (i_item.charge_pct > base_pct) ||
                           ($signed(i_item.now_seconds) < $signed(base_stamp));
                    if (!move && 7'(base_pct - i_item.charge_pct) >= cfg_reanchor)
                        move = 1'b1;
                    level_pct  = i_item.charge_pct;
                    on_charger = i_item.charging_flag;
                    if (move) begin
                        anchor_set = 1'b1;
                        base_pct   = i_item.charge_pct;
                        base_stamp = i_item.now_seconds;
                    end
                    samples_seen++;
                end else begin
                    want = runtime_for(i_item.now_seconds);
                    answers_due.push_back(want);
                    queries_seen++;
                    if (want.estimate_valid) estimates_seen++;
                end
            end
        end
        o_fail_count     <= fail_total;
        o_pending        <= answers_due.size();
        o_sample_count   <= samples_seen;
        o_query_count    <= queries_seen;
        o_estimate_count <= estimates_seen;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the battery runtime estimator
// Runs a directed pass over the anchor and estimate corner cases, then
// several register settings, each with random discharge runs mixed with
// charging, clock jumps and noise. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

    localparam int         PHASES          = 6;
    localparam int         ITEMS_PER_PHASE = 80;
    localparam int         SETTLE_CYCLES   = 4;
    localparam int         DRAIN_CYCLES    = 60;
    localparam int         STALL_LIMIT     = 2000;
    // word index with no register behind it
    localparam logic [1:0] REG_SPARE       = 2'd3;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    bre_pkg::t_item   i_item;
    logic             o_result_strobe;
    bre_pkg::t_result o_result;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [3:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    int               fail_count;
    int               pending;
    int               sample_count;
    int               query_count;
    int               estimate_count;

    // state of the random discharge run
    logic [6:0]       run_pct;
    logic [31:0]      run_time;

    battery_runtime_estimator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    bre_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_item           (i_item),
        .i_result_strobe  (o_result_strobe),
        .i_result         (o_result),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_prdata         (prdata),
        .i_pready         (pready),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_sample_count   (sample_count),
        .o_query_count    (query_count),
        .o_estimate_count (estimate_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hold one item until it is taken; start stays high on return
    task automatic push_item(input bre_pkg::t_item it);
        i_item <= it;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send(input logic kind, input int pct, input logic charging,
                        input int stamp);
        bre_pkg::t_item it;
        it.req_type      = kind;
        it.charge_pct    = 7'(pct);
        it.charging_flag = charging;
        it.now_seconds   = stamp;
        push_item(it);
    endtask

    // stop sending and wait until every query has been answered
    task automatic wait_idle(input int settle);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // one register transfer: setup cycle, then access until pready
    task automatic apb_access(input logic write_en, input logic [1:0] reg_idx,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 150);
    endfunction

    // mostly discharge runs with random content, plus charging and noise
    task automatic random_traffic_item();
        bre_pkg::t_item it;
        int             pick;
        int             step;
        pick             = $urandom_range(0, 99);
        it.req_type      = bre_pkg::REQ_SAMPLE;
        it.charge_pct    = 7'($urandom_range(0, 127));
        it.charging_flag = 1'($urandom_range(0, 1));
        it.now_seconds   = $urandom;
        if (pick < 5) begin
            // fresh run from a high level at a random time
            run_pct          = 7'($urandom_range(30, 127));
            run_time         = $urandom;
            it.charge_pct    = run_pct;
            it.charging_flag = 1'b0;
            it.now_seconds   = run_time;
        end else if (pick < 45) begin
            // discharge step
            step = $urandom_range(0, 3);
            if (step > run_pct) step = run_pct;
            run_pct          = run_pct - 7'(step);
            run_time         = run_time + 32'($urandom_range(0, 20000));
            it.charge_pct    = run_pct;
            it.charging_flag = 1'b0;
            it.now_seconds   = run_time;
        end else if (pick < 80) begin
            // query some time after the latest sample
            it.req_type = bre_pkg::REQ_QUERY;
            if (pick < 75) it.now_seconds = run_time + 32'($urandom_range(0, 400000));
            else           it.now_seconds = run_time + $urandom;
        end else if (pick < 88) begin
            // plugged in at some level
            run_pct          = it.charge_pct;
            it.charging_flag = 1'b1;
            it.now_seconds   = run_time;
        end else if (pick >= 94) begin
            it.req_type = bre_pkg::REQ_QUERY;
        end
        push_item(it);
    endtask

    // watchdog on cycles with no transfer of any kind
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_result_strobe || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int          min_tab[PHASES];
        int          reanchor_tab[PHASES];
        int          limit_tab[PHASES];
        logic [31:0] min_val;
        logic [31:0] reanchor_val;
        logic [31:0] limit_val;
        logic        steady;
        int          gap;
        min_tab      = '{0, 100, 1, 2, 0, 0};
        reanchor_tab = '{100, 1, 0, 20, 3, 0};
        limit_tab    = '{65535, 0, 255, 9999, 1, 0};
        run_pct      = 7'd100;
        run_time     = '0;
        steady       = 1'b0;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_item       <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass with the reset register values
        send(bre_pkg::REQ_QUERY,  0,   1'b0, 1000);          // no anchor yet
        send(bre_pkg::REQ_SAMPLE, 100, 1'b0, 0);
        send(bre_pkg::REQ_SAMPLE, 99,  1'b0, 100);
        send(bre_pkg::REQ_QUERY,  0,   1'b0, 200);           // drop below minimum
        send(bre_pkg::REQ_SAMPLE, 90,  1'b0, 1000);
        send(bre_pkg::REQ_QUERY,  0,   1'b0, 0);             // no time elapsed
        send(bre_pkg::REQ_QUERY,  0,   1'b0, -5);            // query before anchor
        send(bre_pkg::REQ_QUERY,  0,   1'b0, 36000);
        send(bre_pkg::REQ_QUERY,  0,   1'b0, 32'h7FFF_FFFF); // saturates
        send(bre_pkg::REQ_SAMPLE, 127, 1'b1, 50);            // plugged in
        send(bre_pkg::REQ_QUERY,  0,   1'b0, 5000);
        send(bre_pkg::REQ_SAMPLE, 127, 1'b0, 32'h8000_0000); // clock went back
        send(bre_pkg::REQ_SAMPLE, 110, 1'b0, 0);
        send(bre_pkg::REQ_QUERY,  0,   1'b0, 32'h7FFF_FFFF); // widest elapsed time
        send(bre_pkg::REQ_SAMPLE, 0,   1'b0, 10);            // big drop moves anchor
        send(bre_pkg::REQ_QUERY,  0,   1'b0, 100000);        // zero drop
        send(bre_pkg::REQ_SAMPLE, 64,  1'b0, 20);            // rise moves anchor
        send(bre_pkg::REQ_SAMPLE, 60,  1'b0, 3620);
        send(bre_pkg::REQ_QUERY,  0,   1'b0, 14420);
        send(bre_pkg::REQ_SAMPLE, 44,  1'b0, 7220);          // drop equals threshold
        send(bre_pkg::REQ_QUERY,  0,   1'b0, 7221);
        wait_idle(SETTLE_CYCLES);

        // random traffic under several register settings
        for (int p = 0; p < PHASES; p++) begin
            min_val      = min_tab[p];
            reanchor_val = reanchor_tab[p];
            limit_val    = limit_tab[p];
            if (p == PHASES - 1) begin
                min_val      = $urandom_range(0, 100);
                reanchor_val = $urandom_range(1, 100);
                limit_val    = $urandom_range(0, 65535);
            end
            apb_access(1'b1, bre_pkg::REG_MIN_DROP,   min_val);
            apb_access(1'b1, bre_pkg::REG_REANCHOR,   reanchor_val);
            apb_access(1'b1, bre_pkg::REG_HOUR_LIMIT, limit_val);
            if (p == 3) apb_access(1'b1, REG_SPARE, 32'h0000_007F);
            apb_access(1'b0, bre_pkg::REG_MIN_DROP,   '0);
            apb_access(1'b0, bre_pkg::REG_REANCHOR,   '0);
            apb_access(1'b0, bre_pkg::REG_HOUR_LIMIT, '0);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 30 == 0) steady = ($urandom_range(0, 3) == 0);
                random_traffic_item();
                if ($urandom_range(0, 39) == 0) begin
                    // hold off until every query is answered
                    wait_idle(0);
                end else begin
                    gap = steady ? 0 : pick_gap();
                    if (gap > 0) begin
                        start <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
            wait_idle(SETTLE_CYCLES);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d samples and %0d queries, %0d of them with an estimate",
                 sample_count, query_count, estimate_count);
        $display("under %0d register settings including the reset values", PHASES + 1);
        if (pending != 0) $display("%0d queries never answered", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/bre_pkg.sv
sv/bre_ctrl.sv
sv/bre_dp.sv
sv/battery_runtime_estimator.sv
sv/bre_chk.sv
tb/bre_checker.sv
tb/testbench.sv
